>>> rtl/core/lmd_pkg.sv
// Shared constants and types for the 3x3 local maximum detector.
// No dependencies; every other file of the block but lmd_ram imports this package.
`default_nettype none

package lmd_pkg;

  localparam int MAX_SIZE       = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int FRAME_SIZE_W = 11;
  localparam int POS_W        = 10;

  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_MIN = 11'd3;
  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RST = 11'd3;

  localparam int WIN_DIM    = 3;
  localparam int WIN_TAPS   = WIN_DIM * WIN_DIM;
  localparam int WIN_CENTRE = WIN_TAPS / 2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } lmd_pos_t;

endpackage

`default_nettype wire

>>> rtl/core/lmd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
`default_nettype none

module lmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output      logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/lmd_front.sv
// Front end: request intake, raster counters, line buffer RAM and the 3x3 window.
// Pushes one record per interior pixel into the queue. Uses lmd_pkg and lmd_ram.
`default_nettype none

module lmd_front #(
  parameter int PIXEL_BITS = lmd_pkg::DEF_PIXEL_BITS,
  parameter int REC_W      = lmd_pkg::WIN_TAPS * PIXEL_BITS + $bits(lmd_pkg::lmd_pos_t),
  parameter int Q_DEPTH    = lmd_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lmd_pkg::FRAME_SIZE_W-1:0]     cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic [PIXEL_BITS-1:0]                pixel_i,
  input  wire logic [$clog2(Q_DEPTH+1)-1:0]         q_count_i,
  output      logic                                 push_o,
  output      logic [REC_W-1:0]                     push_data_o
);

  import lmd_pkg::*;

  localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [CW-1:0] nm1_q, cfg_nm1;

  logic                          s1_valid_q;
  logic signed [PIXEL_BITS-1:0]  s1_pix_q;
  logic [CW-1:0]                 s1_addr_q;
  logic                          s1_inner_q;
  lmd_pos_t                      s1_pos_q;

  logic signed [PIXEL_BITS-1:0]  win_q [WIN_TAPS];
  logic signed [PIXEL_BITS-1:0]  win_d [WIN_TAPS];

  logic [2*PIXEL_BITS-1:0]       lb_rdata;
  logic [2*PIXEL_BITS-1:0]       lb_wdata;
  logic signed [PIXEL_BITS-1:0]  lb_mid, lb_top;
  logic                          accept;
  logic                          inner;
  lmd_pos_t                      pos;

  // Hold off while the queue could not absorb everything already in flight.
  assign in_stall_o = (int'(q_count_i) + int'(s1_valid_q)) >= Q_DEPTH;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (cfg_wdata_i < FRAME_SIZE_MIN) begin
      cfg_nm1 = CW'(FRAME_SIZE_MIN - 1'b1);
    end else if (int'(cfg_wdata_i) > MAX_SIZE) begin
      cfg_nm1 = CW'(MAX_SIZE - 1);
    end else begin
      cfg_nm1 = CW'(cfg_wdata_i - 1'b1);
    end
  end

  // Advance the raster position, wrapping at the frame edge.
  always_comb begin
    row_d = row_q;
    col_d = col_q + 1'b1;
    if (col_q == nm1_q) begin
      col_d = '0;
      row_d = (row_q == nm1_q) ? '0 : row_q + 1'b1;
    end
  end

  assign inner    = (row_q >= CW'(2)) && (col_q >= CW'(2));
  assign pos.row  = POS_W'(row_q - 1'b1);
  assign pos.col  = POS_W'(col_q - 1'b1);
  assign pos.last = (row_q == nm1_q) && (col_q == nm1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q      <= CW'(FRAME_SIZE_RST - 1'b1);
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (cfg_we_i) begin
        nm1_q <= cfg_nm1;
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pixel_i;
      s1_addr_q  <= col_q;
      s1_inner_q <= inner;
      s1_pos_q   <= pos;
    end
  end

  // Line buffer word: upper half is the previous row, lower half the row before it.
  assign lb_mid   = lb_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign lb_top   = lb_rdata[PIXEL_BITS-1:0];
  assign lb_wdata = {s1_pix_q, lb_mid};

  lmd_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_SIZE)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (lb_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (lb_rdata)
  );

  always_comb begin
    for (int i = 0; i < WIN_DIM; i++) begin
      win_d[i*WIN_DIM]     = win_q[i*WIN_DIM + 1];
      win_d[i*WIN_DIM + 1] = win_q[i*WIN_DIM + 2];
    end
    win_d[WIN_DIM - 1]     = lb_top;
    win_d[2*WIN_DIM - 1]   = lb_mid;
    win_d[3*WIN_DIM - 1]   = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        win_q[k] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  assign push_o = s1_valid_q && s1_inner_q;

  always_comb begin
    push_data_o[$bits(lmd_pos_t)-1:0] = s1_pos_q;
    for (int k = 0; k < WIN_TAPS; k++) begin
      push_data_o[$bits(lmd_pos_t) + k*PIXEL_BITS +: PIXEL_BITS] = win_d[k];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lmd_fifo.sv
// Short queue between front and back end of the detector.
// Uses lmd_pkg for the default depth.
`default_nettype none

module lmd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = lmd_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [WIDTH-1:0]              wdata_i,
  input  wire logic                          pop_i,
  output      logic [WIDTH-1:0]              rdata_o,
  output      logic                          empty_o,
  output      logic [$clog2(DEPTH+1)-1:0]    count_o
);

  import lmd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]           mem_q [DEPTH];
  logic [PW-1:0]              wr_ptr_q, rd_ptr_q;
  logic [$clog2(DEPTH+1)-1:0] count_q;

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lmd_back.sv
// Back end: judges the queued 3x3 window against its centre and drives the result register.
// Uses lmd_pkg for window geometry and the position record.
`default_nettype none

module lmd_back #(
  parameter int PIXEL_BITS = lmd_pkg::DEF_PIXEL_BITS,
  parameter int REC_W      = lmd_pkg::WIN_TAPS * PIXEL_BITS + $bits(lmd_pkg::lmd_pos_t)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [REC_W-1:0]                 head_i,
  input  wire logic                             empty_i,
  output      logic                             pop_o,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [lmd_pkg::POS_W-1:0]        row_o,
  output      logic [lmd_pkg::POS_W-1:0]        col_o,
  output      logic [PIXEL_BITS-1:0]            max_value_o,
  output      logic                             is_max_o,
  output      logic                             last_o
);

  import lmd_pkg::*;

  logic signed [PIXEL_BITS-1:0] win [WIN_TAPS];
  logic signed [PIXEL_BITS-1:0] centre;
  lmd_pos_t                     pos;
  logic                         is_max;

  logic                         out_valid_q;
  lmd_pos_t                     pos_q;
  logic [PIXEL_BITS-1:0]        value_q;
  logic                         is_max_q;

  always_comb begin
    pos = head_i[$bits(lmd_pos_t)-1:0];
    for (int k = 0; k < WIN_TAPS; k++) begin
      win[k] = head_i[$bits(lmd_pos_t) + k*PIXEL_BITS +: PIXEL_BITS];
    end
  end

  assign centre = win[WIN_CENTRE];

  // Strict maximum: any tie with a neighbour clears the flag.
  always_comb begin
    is_max = 1'b1;
    for (int k = 0; k < WIN_TAPS; k++) begin
      if (k != WIN_CENTRE && win[k] >= centre) begin
        is_max = 1'b0;
      end
    end
  end

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pos_q    <= pos;
      value_q  <= is_max ? centre : '0;
      is_max_q <= is_max;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = pos_q.row;
  assign col_o       = pos_q.col;
  assign max_value_o = value_q;
  assign is_max_o    = is_max_q;
  assign last_o      = pos_q.last;

endmodule

`default_nettype wire

>>> rtl/core/local_max_3x3_detector.sv
// Top level of the 3x3 local maximum detector: front end, queue and back end.
// Uses lmd_pkg, lmd_front, lmd_fifo and lmd_back.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------------
//   config   | in        | cfg_we_i               | cfg_wdata_i (frame size)
//   pixel    | in        | in_valid_i / in_stall_o| pixel_i
//   result   | out       | out_valid_o/out_stall_i| row_o col_o max_value_o is_max_o last_o
//
// One pixel per clock sustained while in_stall_o is low. The pixel completing a window
// reaches the output via the line buffer read, the queue write and the result register.
// Border pixels produce no result. A four-entry queue decouples the window from the
// result register, so pixels keep flowing until the queue fills under a stalled output.
// Reset clears counters, window and queue; the line buffer RAM needs no clearing.
`default_nettype none

module local_max_3x3_detector #(
  parameter int PIXEL_BITS = lmd_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lmd_pkg::FRAME_SIZE_W-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [PIXEL_BITS-1:0]            pixel_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [lmd_pkg::POS_W-1:0]        row_o,
  output      logic [lmd_pkg::POS_W-1:0]        col_o,
  output      logic [PIXEL_BITS-1:0]            max_value_o,
  output      logic                             is_max_o,
  output      logic                             last_o
);

  import lmd_pkg::*;

  localparam int REC_W = WIN_TAPS * PIXEL_BITS + $bits(lmd_pos_t);

  logic                             push, pop, empty;
  logic [REC_W-1:0]                 push_data, head;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  lmd_front #(
    .PIXEL_BITS (PIXEL_BITS),
    .REC_W      (REC_W),
    .Q_DEPTH    (QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lmd_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .count_o (q_count)
  );

  lmd_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .REC_W      (REC_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_o       (row_o),
    .col_o       (col_o),
    .max_value_o (max_value_o),
    .is_max_o    (is_max_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/lmd_checker.sv
// Port-level checks for the 3x3 local maximum detector, bound to the top level.
// Uses lmd_pkg for port widths.
`default_nettype none

module lmd_checker #(
  parameter int PIXEL_BITS = lmd_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  input  wire logic [lmd_pkg::POS_W-1:0]        row_o,
  input  wire logic [lmd_pkg::POS_W-1:0]        col_o,
  input  wire logic [PIXEL_BITS-1:0]            max_value_o,
  input  wire logic                             is_max_o,
  input  wire logic                             last_o
);

  import lmd_pkg::*;

  a_no_result_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result request shown during reset");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result request withdrawn");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(row_o) && $stable(col_o)
      && $stable(max_value_o) && $stable(is_max_o) && $stable(last_o))
    else $error("stalled result payload changed");

  a_suppressed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_max_o |-> max_value_o == '0)
    else $error("suppressed pixel carries a non-zero value");

  a_last_on_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> row_o == col_o)
    else $error("frame end flagged off the final interior pixel");

endmodule

bind local_max_3x3_detector lmd_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_lmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .row_o       (row_o),
  .col_o       (col_o),
  .max_value_o (max_value_o),
  .is_max_o    (is_max_o),
  .last_o      (last_o)
);

`default_nettype wire
